### rtl/touch_zone_press_release_detector_assert.svh
// ----------------------------------------------------------------------------
// touch_zone_press_release_detector_assert.svh
// Assertion macros for the touch zone detector, empty with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TOUCH_ZONE_PRESS_RELEASE_DETECTOR_ASSERT_SVH
`define TOUCH_ZONE_PRESS_RELEASE_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TZPR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tzprd assertion failed");

// next-cycle implication
`define TZPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tzprd assertion failed");

`else

`define TZPR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define TZPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/tzprd_pkg.sv
// ----------------------------------------------------------------------------
// tzprd_pkg
// Types and constants shared by the touch zone detector modules.
// ----------------------------------------------------------------------------
package tzprd_pkg;

    localparam int FUNC_W     = 3;
    localparam int KIND_W     = 2;
    localparam int SAMPLE_W   = 12;
    localparam int ZIDX_W     = 4;
    localparam int COORD_W    = 11;
    localparam int SIZE_W     = 10;
    localparam int LEVEL_W    = 4;
    localparam int SCALE_W    = 16;
    localparam int ORIGIN_W   = 10;
    localparam int PROD_W     = SAMPLE_W + SCALE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 5;

    localparam logic [CNT_W-1:0]   MAX_RESULTS = 5'd16;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd15;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 4'd1;

    localparam logic [SCALE_W-1:0]  RST_X_SCALE   = 16'd20972;
    localparam logic [SCALE_W-1:0]  RST_Y_SCALE   = 16'd15729;
    localparam logic [ORIGIN_W-1:0] RST_Y_ORIGIN  = 10'd240;
    localparam logic [SAMPLE_W-1:0] RST_DEADBAND  = 12'd10;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 12'd50;

    localparam logic EV_PRESS   = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 3'd0,
        FUNC_WRITE  = 3'd1,
        FUNC_SET_EN = 3'd2,
        FUNC_PAUSE  = 3'd3,
        FUNC_RESUME = 3'd4,
        FUNC_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_X     = 2'd0,
        KIND_Y     = 2'd1,
        KIND_PRESS = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_SCALE   = 3'd0,
        CFG_Y_SCALE   = 3'd1,
        CFG_Y_ORIGIN  = 3'd2,
        CFG_DEADBAND  = 3'd3,
        CFG_THRESHOLD = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCALE,
        ST_SCAN,
        ST_FLUSH,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
    } t_rect;

    // controller -> datapath
    typedef struct packed {
        logic cap_item;
        logic mul_go;
        logic scale_wr;
        logic zone_wr;
        logic en_wr;
        logic clr_zones;
        logic clr_last;
        logic scan_start;
        logic scan_run;
        logic sweep_start;
        logic sweep_run;
        logic flush;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_func func;
        t_kind kind;
        logic  val_zero;
        logic  above_thr;
        logic  passes_db;
        logic  scan_done;
        logic  flush_done;
        logic  sweep_done;
    } t_sts;

endpackage

### rtl/tzprd_ctrl.sv
// ----------------------------------------------------------------------------
// tzprd_ctrl
// Sequencer: decodes each word and steps the datapath through it.
// ----------------------------------------------------------------------------
`include "touch_zone_press_release_detector_assert.svh"

module tzprd_ctrl import tzprd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (i_sts.func)
                    FUNC_SAMPLE: begin
                        case (i_sts.kind)
                            KIND_X, KIND_Y: begin
                                if (i_sts.passes_db) begin
                                    n_state = ST_SCALE;
                                end
                            end
                            KIND_PRESS: begin
                                if (i_sts.val_zero || i_sts.above_thr) begin
                                    n_state = ST_SCAN;
                                end
                            end
                            default: n_state = ST_IDLE;
                        endcase
                    end
                    FUNC_PAUSE, FUNC_RESUME: n_state = ST_SWEEP;
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_SCALE: n_state = ST_IDLE;
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_sts.flush_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (i_sts.sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.cap_item = i_in_valid;
            end
            ST_EXEC: begin
                case (i_sts.func)
                    FUNC_SAMPLE: begin
                        case (i_sts.kind)
                            KIND_X, KIND_Y: o_cmd.mul_go = i_sts.passes_db;
                            KIND_PRESS: begin
                                // zero pressure releases even with a zero threshold
                                o_cmd.clr_last   = i_sts.val_zero;
                                o_cmd.scan_start = i_sts.val_zero || i_sts.above_thr;
                            end
                            default: o_cmd.scan_start = 1'b0;
                        endcase
                    end
                    FUNC_WRITE:  o_cmd.zone_wr   = 1'b1;
                    FUNC_SET_EN: o_cmd.en_wr     = 1'b1;
                    FUNC_PAUSE: begin
                        o_cmd.clr_last    = 1'b1;
                        o_cmd.sweep_start = 1'b1;
                    end
                    FUNC_RESUME: o_cmd.sweep_start = 1'b1;
                    FUNC_CLEAR:  o_cmd.clr_zones   = 1'b1;
                    default:     o_cmd.clr_zones   = 1'b0;
                endcase
            end
            ST_SCALE: o_cmd.scale_wr  = 1'b1;
            ST_SCAN:  o_cmd.scan_run  = 1'b1;
            ST_FLUSH: o_cmd.flush     = 1'b1;
            ST_SWEEP: o_cmd.sweep_run = 1'b1;
            default:  o_cmd           = '0;
        endcase
    end

    `TZPR_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_EXEC)
    `TZPR_ASSERT_NEXT(a_flush_to_idle, i_clk, i_rst_n, r_state == ST_FLUSH && i_sts.flush_done, r_state == ST_IDLE)
    `TZPR_ASSERT_IMPLY(a_ready_in_idle, i_clk, i_rst_n, o_in_ready, r_state == ST_IDLE)

endmodule

### rtl/tzprd_dp.sv
// ----------------------------------------------------------------------------
// tzprd_dp
// Datapath: config registers, coordinate scaling, zone tables, zone scan
// and the result holding stages.
// ----------------------------------------------------------------------------
`include "touch_zone_press_release_detector_assert.svh"

module tzprd_dp import tzprd_pkg::*; #(
    parameter int ZONE_COUNT = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    input  logic [FUNC_W-1:0]            i_func,
    input  logic [KIND_W-1:0]            i_sample_kind,
    input  logic [SAMPLE_W-1:0]          i_sample_value,
    input  logic [ZIDX_W-1:0]            i_zone_index,
    input  logic signed [COORD_W-1:0]    i_zone_left,
    input  logic signed [COORD_W-1:0]    i_zone_top,
    input  logic [SIZE_W-1:0]            i_zone_width,
    input  logic [SIZE_W-1:0]            i_zone_height,
    input  logic                         i_zone_enable,
    input  logic                         i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_event_kind,
    output logic [ZIDX_W-1:0]            o_event_zone,
    output logic                         o_last_event
);

    localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int LW = $clog2(ZONE_COUNT + 1);
    localparam int CW = (LW > ZIDX_W) ? LW : ZIDX_W;
    localparam logic [LW-1:0] NONE = LW'(ZONE_COUNT);

    // config
    logic [SCALE_W-1:0]  r_x_scale;
    logic [SCALE_W-1:0]  r_y_scale;
    logic [ORIGIN_W-1:0] r_y_origin;
    logic [SAMPLE_W-1:0] r_deadband;
    logic [SAMPLE_W-1:0] r_threshold;

    // captured word
    t_func                     r_func;
    t_kind                     r_kind;
    logic [SAMPLE_W-1:0]       r_val;
    logic [ZIDX_W-1:0]         r_idx;
    t_rect                     r_rect_in;
    logic                      r_en;

    // coordinate state
    logic [SAMPLE_W-1:0]       r_raw_x;
    logic [SAMPLE_W-1:0]       r_raw_y;
    logic signed [COORD_W-1:0] r_scr_x;
    logic signed [COORD_W-1:0] r_scr_y;
    logic [PROD_W-1:0]         r_prod;
    logic [LW-1:0]             r_last;

    // zone tables
    t_rect                     rect_mem [ZONE_COUNT];
    logic [LEVEL_W-1:0]        lvl_mem  [ZONE_COUNT];
    logic [ZONE_COUNT-1:0]     r_rect_ok;
    logic [ZONE_COUNT-1:0]     r_lvl_ok;
    t_rect                     r_rect_q;
    logic [LEVEL_W-1:0]        r_lvl_q;
    logic                      r_rect_okq;
    logic                      r_lvl_okq;

    // scan pipeline
    logic [LW-1:0]             r_scan_idx;
    logic                      r_eval_vld;
    logic [ZW-1:0]             r_eval_idx;
    logic                      r_scan_rel;
    logic                      r_sweep_up;
    logic [CNT_W-1:0]          r_emit_cnt;

    // result stages
    logic                      r_pend_vld;
    logic                      r_pend_kind;
    logic [ZIDX_W-1:0]         r_pend_zone;
    logic                      r_out_vld;
    logic                      r_out_kind;
    logic [ZIDX_W-1:0]         r_out_zone;
    logic                      r_out_last;

    logic [SAMPLE_W-1:0]       kept;
    logic [SAMPLE_W-1:0]       diff;
    logic [SCALE_W-1:0]        sel_scale;
    logic [PROD_W-1:0]         prod_c;
    logic [SAMPLE_W-1:0]       scaled;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W+1:0] y_diff;
    logic signed [COORD_W-1:0] new_y;
    logic                      idx_ok;
    logic [ZW-1:0]             item_addr;
    logic [ZW-1:0]             rd_addr;
    logic                      advance;
    logic                      issue;
    t_rect                     rect_eff;
    logic [LEVEL_W-1:0]        lvl_eff;
    logic signed [COORD_W:0]   x_e, y_e, l_e, t_e, r_e, b_e;
    logic                      hit;
    logic                      want;
    logic                      emit_now;
    logic                      out_free;
    logic                      stall;
    logic                      scan_move;
    logic                      flush_move;
    logic                      out_load;
    logic                      wb_en;
    logic [LEVEL_W-1:0]        wb_val;
    logic                      lvl_we;
    logic [ZW-1:0]             lvl_wa;
    logic [LEVEL_W-1:0]        lvl_wd;
    logic                      rect_we;

    // ---------------- config port (always ready) ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale   <= RST_X_SCALE;
            r_y_scale   <= RST_Y_SCALE;
            r_y_origin  <= RST_Y_ORIGIN;
            r_deadband  <= RST_DEADBAND;
            r_threshold <= RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_X_SCALE:   r_x_scale   <= i_cfg_data;
                CFG_Y_SCALE:   r_y_scale   <= i_cfg_data;
                CFG_Y_ORIGIN:  r_y_origin  <= i_cfg_data[ORIGIN_W-1:0];
                CFG_DEADBAND:  r_deadband  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                default:       r_threshold <= r_threshold;
            endcase
        end
    end

    // ---------------- word capture ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_func           <= t_func'(i_func);
            r_kind           <= t_kind'(i_sample_kind);
            r_val            <= i_sample_value;
            r_idx            <= i_zone_index;
            r_rect_in.left   <= i_zone_left;
            r_rect_in.top    <= i_zone_top;
            r_rect_in.width  <= i_zone_width;
            r_rect_in.height <= i_zone_height;
            r_en             <= i_zone_enable;
        end
    end

    // ---------------- deadband and scaling ----------------
    assign kept      = (r_kind == KIND_Y) ? r_raw_y : r_raw_x;
    assign diff      = (r_val > kept) ? (r_val - kept) : (kept - r_val);
    assign sel_scale = (r_kind == KIND_Y) ? r_y_scale : r_x_scale;
    assign prod_c    = r_val * sel_scale;
    assign scaled    = r_prod[PROD_W-1:SCALE_W];
    assign new_x     = (scaled > 12'd1023) ? 11'sd1023 : COORD_W'({1'b0, scaled[9:0]});
    assign y_diff    = signed'({3'b000, r_y_origin}) - signed'({1'b0, scaled});

    always_comb begin
        if (y_diff < -13'sd1024) begin
            new_y = -11'sd1024;
        end else if (y_diff > 13'sd1023) begin
            new_y = 11'sd1023;
        end else begin
            new_y = y_diff[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_prod <= prod_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_x <= '0;
            r_raw_y <= '0;
            r_scr_x <= '0;
            r_scr_y <= '0;
        end else if (i_cmd.scale_wr) begin
            if (r_kind == KIND_Y) begin
                r_scr_y <= new_y;
                r_raw_y <= r_val;
            end else begin
                r_scr_x <= new_x;
                r_raw_x <= r_val;
            end
        end
    end

    // ---------------- scan / sweep pipeline ----------------
    assign idx_ok    = CW'(r_idx) < CW'(ZONE_COUNT);
    assign item_addr = ZW'(r_idx);
    assign rd_addr   = r_scan_idx[ZW-1:0];
    assign out_free  = !r_out_vld || i_out_ready;

    assign rect_eff = r_rect_okq ? r_rect_q : '0;
    assign lvl_eff  = r_lvl_okq ? r_lvl_q : '0;

    // strict containment, 12-bit signed so the far edges cannot overflow
    assign x_e = {r_scr_x[COORD_W-1], r_scr_x};
    assign y_e = {r_scr_y[COORD_W-1], r_scr_y};
    assign l_e = {rect_eff.left[COORD_W-1], rect_eff.left};
    assign t_e = {rect_eff.top[COORD_W-1], rect_eff.top};
    assign r_e = l_e + signed'({2'b00, rect_eff.width});
    assign b_e = t_e + signed'({2'b00, rect_eff.height});
    assign hit = (lvl_eff == LEVEL_ONE) && (x_e > l_e) && (x_e < r_e) &&
                 (y_e > t_e) && (y_e < b_e);

    assign want     = i_cmd.scan_run && r_eval_vld &&
                      (r_scan_rel ? hit : (hit && (r_last != LW'(r_eval_idx))));
    assign emit_now = want && (r_emit_cnt < MAX_RESULTS);
    assign stall    = emit_now && r_pend_vld && !out_free;
    assign advance  = (i_cmd.scan_run && !stall) || i_cmd.sweep_run;
    assign issue    = advance && (r_scan_idx < NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_eval_vld <= 1'b0;
        end else if (i_cmd.scan_start || i_cmd.sweep_start) begin
            r_scan_idx <= '0;
            r_eval_vld <= 1'b0;
        end else if (advance) begin
            r_eval_vld <= issue;
            if (issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_eval_idx <= rd_addr;
            r_rect_okq <= r_rect_ok[rd_addr];
            r_lvl_okq  <= r_lvl_ok[rd_addr];
        end
        if (i_cmd.scan_start) begin
            r_scan_rel <= (r_val == '0);
        end
        if (i_cmd.sweep_start) begin
            r_sweep_up <= (r_func == FUNC_PAUSE);
        end
    end

    // level write-back during pause / resume
    always_comb begin
        wb_en  = 1'b0;
        wb_val = lvl_eff;
        if (i_cmd.sweep_run && r_eval_vld && (lvl_eff != '0)) begin
            if (r_sweep_up) begin
                wb_en  = (lvl_eff != LEVEL_MAX);
                wb_val = lvl_eff + 1'b1;
            end else begin
                wb_en  = 1'b1;
                wb_val = lvl_eff - 1'b1;
            end
        end
    end

    assign rect_we = i_cmd.zone_wr && idx_ok;
    assign lvl_we  = wb_en || ((i_cmd.zone_wr || i_cmd.en_wr) && idx_ok);
    assign lvl_wa  = wb_en ? r_eval_idx : item_addr;
    assign lvl_wd  = wb_en ? wb_val :
                     (i_cmd.zone_wr ? LEVEL_ONE : LEVEL_W'(r_en));

    always_ff @(posedge i_clk) begin
        if (rect_we) begin
            rect_mem[item_addr] <= r_rect_in;
        end
        if (issue) begin
            r_rect_q <= rect_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            lvl_mem[lvl_wa] <= lvl_wd;
        end
        if (issue) begin
            r_lvl_q <= lvl_mem[rd_addr];
        end
    end

    // entries not marked read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_zones) begin
            r_rect_ok <= '0;
            r_lvl_ok  <= '0;
        end else begin
            if (rect_we) begin
                r_rect_ok[item_addr] <= 1'b1;
            end
            if ((i_cmd.zone_wr || i_cmd.en_wr) && idx_ok) begin
                r_lvl_ok[item_addr] <= 1'b1;
            end
        end
    end

    // last pressed zone follows every press hit, even past the result cap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_last) begin
            r_last <= NONE;
        end else if (want && !stall && !r_scan_rel) begin
            r_last <= LW'(r_eval_idx);
        end
    end

    // ---------------- result stages ----------------
    // one result is held back until it is known whether another follows
    assign scan_move  = emit_now && !stall && r_pend_vld;
    assign flush_move = i_cmd.flush && r_pend_vld && out_free;
    assign out_load   = scan_move || flush_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_emit_cnt <= '0;
        end else if (i_cmd.scan_start) begin
            r_pend_vld <= 1'b0;
            r_emit_cnt <= '0;
        end else if (emit_now && !stall) begin
            r_pend_vld <= 1'b1;
            r_emit_cnt <= r_emit_cnt + 1'b1;
        end else if (flush_move) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now && !stall) begin
            r_pend_kind <= r_scan_rel ? EV_RELEASE : EV_PRESS;
            r_pend_zone <= ZIDX_W'(r_eval_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind <= r_pend_kind;
            r_out_zone <= r_pend_zone;
            r_out_last <= flush_move;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_event_kind = r_out_kind;
    assign o_event_zone = r_out_zone;
    assign o_last_event = r_out_last;

    // ---------------- status ----------------
    always_comb begin
        o_sts            = '0;
        o_sts.func       = r_func;
        o_sts.kind       = r_kind;
        o_sts.val_zero   = (r_val == '0);
        o_sts.above_thr  = (r_val > r_threshold);
        o_sts.passes_db  = (diff > r_deadband);
        o_sts.scan_done  = (r_scan_idx == NONE) && !r_eval_vld;
        o_sts.sweep_done = (r_scan_idx == NONE) && !r_eval_vld;
        o_sts.flush_done = !r_pend_vld;
    end

    `TZPR_ASSERT_IMPLY(a_out_no_overwrite, i_clk, i_rst_n, out_load, !r_out_vld || i_out_ready)
    `TZPR_ASSERT_IMPLY(a_emit_cap, i_clk, i_rst_n, 1'b1, r_emit_cnt <= MAX_RESULTS)
    `TZPR_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, stall, r_eval_vld && $stable(r_eval_idx))

endmodule

### rtl/touch_zone_press_release_detector.sv
// ----------------------------------------------------------------------------
// touch_zone_press_release_detector
// Touch panel front end: deadband and scaling of X/Y samples, zone table,
// press and release events for the zones that hold the touch point.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_func .. i_zone_enable
//  out      source     o_out_valid / i_out_ready  o_event_kind, o_event_zone,
//                                                 o_last_event
//  cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One word at a time: a new word is accepted only once the last is done.
//  Scanning pressure and pause/resume read one table entry per cycle, unless
//  the scan is held by an output stall.
//  Output stalls hold the scan once a second hit waits behind a full output.
//  Reset (synchronous): zone tables read as empty at once, no clearing pass.
//  The config port is always ready; results already out stay until taken.
// ----------------------------------------------------------------------------
module touch_zone_press_release_detector import tzprd_pkg::*; #(
    parameter int ZONE_COUNT = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [KIND_W-1:0]         i_sample_kind,
    input  logic [SAMPLE_W-1:0]       i_sample_value,
    input  logic [ZIDX_W-1:0]         i_zone_index,
    input  logic signed [COORD_W-1:0] i_zone_left,
    input  logic signed [COORD_W-1:0] i_zone_top,
    input  logic [SIZE_W-1:0]         i_zone_width,
    input  logic [SIZE_W-1:0]         i_zone_height,
    input  logic                      i_zone_enable,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_event_kind,
    output logic [ZIDX_W-1:0]         o_event_zone,
    output logic                      o_last_event,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tzprd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tzprd_dp #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_sample_kind  (i_sample_kind),
        .i_sample_value (i_sample_value),
        .i_zone_index   (i_zone_index),
        .i_zone_left    (i_zone_left),
        .i_zone_top     (i_zone_top),
        .i_zone_width   (i_zone_width),
        .i_zone_height  (i_zone_height),
        .i_zone_enable  (i_zone_enable),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_event_zone   (o_event_zone),
        .o_last_event   (o_last_event)
    );

endmodule

### tb/tb_touch_zone_press_release_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_zone_press_release_detector
// Streams touch samples and zone table commands into the detector. Each
// word accepted on the input updates a local copy of the touch point and
// zone table, which gives the expected press/release events. Every event
// on the output is checked in order. Both channels idle and stall at
// random. Register settings change between phases, only while idle.
// ----------------------------------------------------------------------------
module tb_touch_zone_press_release_detector;
    import tzprd_pkg::*;

    localparam int ZONE_COUNT       = 16;
    localparam int NO_ZONE          = ZONE_COUNT;
    localparam int SETTLE_CYCLES    = 2 * (ZONE_COUNT + 3) + 2;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int RANDOM_PER_PHASE = 30;
    localparam int PHASES           = 6;

    // func codes the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]         func;
        logic [KIND_W-1:0]         kind;
        logic [SAMPLE_W-1:0]       value;
        logic [ZIDX_W-1:0]         idx;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic                      enable;
    } touch_word_t;

    typedef struct {
        logic              kind;
        logic [ZIDX_W-1:0] zone;
        logic              is_last;
    } zone_event_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [FUNC_W-1:0]         in_func = '0;
    logic [KIND_W-1:0]         in_kind = '0;
    logic [SAMPLE_W-1:0]       in_value = '0;
    logic [ZIDX_W-1:0]         in_idx = '0;
    logic signed [COORD_W-1:0] in_left = '0;
    logic signed [COORD_W-1:0] in_top = '0;
    logic [SIZE_W-1:0]         in_width = '0;
    logic [SIZE_W-1:0]         in_height = '0;
    logic                      in_enable = 1'b0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              ev_kind;
    logic [ZIDX_W-1:0] ev_zone;
    logic              ev_last;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // local copy of the block's registers and state
    logic [SCALE_W-1:0]  cfg_x_scale   = RST_X_SCALE;
    logic [SCALE_W-1:0]  cfg_y_scale   = RST_Y_SCALE;
    logic [ORIGIN_W-1:0] cfg_y_origin  = RST_Y_ORIGIN;
    logic [SAMPLE_W-1:0] cfg_deadband  = RST_DEADBAND;
    logic [SAMPLE_W-1:0] cfg_threshold = RST_THRESHOLD;

    logic [SAMPLE_W-1:0] kept_x = '0;
    logic [SAMPLE_W-1:0] kept_y = '0;
    int                  scr_x = 0;
    int                  scr_y = 0;
    int                  last_zone = NO_ZONE;
    t_rect               zone_rect [ZONE_COUNT] = '{default: '0};
    logic [LEVEL_W-1:0]  zone_level [ZONE_COUNT] = '{default: '0};

    touch_word_t pending_words [$];
    zone_event_t expected_events [$];
    touch_word_t cur_word;
    zone_event_t want;

    int burst_left = 1;
    int gap_left = 0;
    int stall_mode = 0;
    int ready_tick = 0;
    int cycle_count = 0;
    int mismatch_count = 0;

    touch_zone_press_release_detector #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (in_func),
        .i_sample_kind  (in_kind),
        .i_sample_value (in_value),
        .i_zone_index   (in_idx),
        .i_zone_left    (in_left),
        .i_zone_top     (in_top),
        .i_zone_width   (in_width),
        .i_zone_height  (in_height),
        .i_zone_enable  (in_enable),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_event_kind   (ev_kind),
        .o_event_zone   (ev_zone),
        .o_last_event   (ev_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit outside_deadband(logic [SAMPLE_W-1:0] raw,
                                            logic [SAMPLE_W-1:0] kept);
        int diff;
        diff = (raw > kept) ? int'(raw) - int'(kept) : int'(kept) - int'(raw);
        return diff > int'(cfg_deadband);
    endfunction

    function automatic int scale_raw(logic [SAMPLE_W-1:0] raw,
                                     logic [SCALE_W-1:0] factor);
        logic [PROD_W-1:0] prod;
        prod = raw * factor;
        return int'(prod >> 16);
    endfunction

    // strict containment, level must be exactly one
    function automatic bit zone_holds_point(int i);
        int l;
        int t;
        if (zone_level[i] != LEVEL_ONE)
            return 1'b0;
        l = $signed(zone_rect[i].left);
        t = $signed(zone_rect[i].top);
        return scr_x > l && scr_x < l + int'(zone_rect[i].width) &&
               scr_y > t && scr_y < t + int'(zone_rect[i].height);
    endfunction

    function automatic void predict_events(touch_word_t w);
        zone_event_t hits [$];
        int scaled;
        int y;
        hits = {};
        case (w.func)
            FUNC_SAMPLE: begin
                case (w.kind)
                    KIND_X: begin
                        if (outside_deadband(w.value, kept_x)) begin
                            scaled = scale_raw(w.value, cfg_x_scale);
                            scr_x = (scaled > 1023) ? 1023 : scaled;
                            kept_x = w.value;
                        end
                    end
                    KIND_Y: begin
                        if (outside_deadband(w.value, kept_y)) begin
                            y = int'(cfg_y_origin) - scale_raw(w.value, cfg_y_scale);
                            scr_y = (y < -1024) ? -1024 : (y > 1023) ? 1023 : y;
                            kept_y = w.value;
                        end
                    end
                    KIND_PRESS: begin
                        if (w.value == '0) begin
                            last_zone = NO_ZONE;
                            for (int i = 0; i < ZONE_COUNT; i++)
                                if (zone_holds_point(i) && hits.size() < MAX_RESULTS)
                                    hits.push_back('{EV_RELEASE, i[ZIDX_W-1:0], 1'b0});
                        end else if (w.value > cfg_threshold) begin
                            for (int i = 0; i < ZONE_COUNT; i++) begin
                                if (zone_holds_point(i) && last_zone != i) begin
                                    last_zone = i;
                                    if (hits.size() < MAX_RESULTS)
                                        hits.push_back('{EV_PRESS, i[ZIDX_W-1:0], 1'b0});
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_WRITE: begin
                zone_rect[w.idx] = '{w.left, w.top, w.width, w.height};
                zone_level[w.idx] = LEVEL_ONE;
            end
            FUNC_SET_EN: zone_level[w.idx] = w.enable ? LEVEL_ONE : '0;
            FUNC_PAUSE: begin
                last_zone = NO_ZONE;
                for (int i = 0; i < ZONE_COUNT; i++)
                    if (zone_level[i] != '0 && zone_level[i] != LEVEL_MAX)
                        zone_level[i] = zone_level[i] + 1'b1;
            end
            FUNC_RESUME: begin
                for (int i = 0; i < ZONE_COUNT; i++)
                    if (zone_level[i] != '0)
                        zone_level[i] = zone_level[i] - 1'b1;
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < ZONE_COUNT; i++) begin
                    zone_rect[i] = '0;
                    zone_level[i] = '0;
                end
            end
            default: ;
        endcase
        foreach (hits[k]) begin
            hits[k].is_last = (k == hits.size() - 1);
            expected_events.push_back(hits[k]);
        end
    endfunction

    // all fields random; callers override what the operation needs
    function automatic touch_word_t rand_word();
        touch_word_t w;
        w.func   = $urandom_range(0, 7);
        w.kind   = $urandom_range(0, 3);
        w.value  = $urandom_range(0, 4095);
        w.idx    = $urandom_range(0, ZONE_COUNT - 1);
        w.left   = $urandom_range(0, 2047);
        w.top    = $urandom_range(0, 2047);
        w.width  = $urandom_range(0, 1023);
        w.height = $urandom_range(0, 1023);
        w.enable = $urandom_range(0, 1);
        return w;
    endfunction

    function automatic touch_word_t sample_word(logic [KIND_W-1:0] kind, int value);
        touch_word_t w;
        w = rand_word();
        w.func  = FUNC_SAMPLE;
        w.kind  = kind;
        w.value = value[SAMPLE_W-1:0];
        return w;
    endfunction

    function automatic touch_word_t zone_word(int idx, int l, int t, int wd, int ht);
        touch_word_t w;
        w = rand_word();
        w.func   = FUNC_WRITE;
        w.idx    = idx[ZIDX_W-1:0];
        w.left   = l[COORD_W-1:0];
        w.top    = t[COORD_W-1:0];
        w.width  = wd[SIZE_W-1:0];
        w.height = ht[SIZE_W-1:0];
        return w;
    endfunction

    function automatic touch_word_t ctrl_word(logic [FUNC_W-1:0] func, int idx, bit en);
        touch_word_t w;
        w = rand_word();
        w.func   = func;
        w.idx    = idx[ZIDX_W-1:0];
        w.enable = en;
        return w;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_X_SCALE:   cfg_x_scale   = data[SCALE_W-1:0];
            CFG_Y_SCALE:   cfg_y_scale   = data[SCALE_W-1:0];
            CFG_Y_ORIGIN:  cfg_y_origin  = data[ORIGIN_W-1:0];
            CFG_DEADBAND:  cfg_deadband  = data[SAMPLE_W-1:0];
            CFG_THRESHOLD: cfg_threshold = data[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    // wait for every pending word and event, then let a scan run out
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // input driver: bursts of words separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                predict_events(cur_word);
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    in_func   <= cur_word.func;
                    in_kind   <= cur_word.kind;
                    in_value  <= cur_word.value;
                    in_idx    <= cur_word.idx;
                    in_left   <= cur_word.left;
                    in_top    <= cur_word.top;
                    in_width  <= cur_word.width;
                    in_height <= cur_word.height;
                    in_enable <= cur_word.enable;
                    in_valid  <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and ready pattern
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_events.size() == 0) begin
                mismatch_count++;
                $display("%0t: event with none expected: kind %0d zone %0d last %0d",
                         $time, ev_kind, ev_zone, ev_last);
            end else begin
                want = expected_events.pop_front();
                if (ev_kind !== want.kind) begin
                    mismatch_count++;
                    $display("%0t: event kind expected %0d got %0d",
                             $time, want.kind, ev_kind);
                end
                if (ev_zone !== want.zone) begin
                    mismatch_count++;
                    $display("%0t: event zone expected %0d got %0d",
                             $time, want.zone, ev_zone);
                end
                if (ev_last !== want.is_last) begin
                    mismatch_count++;
                    $display("%0t: last flag expected %0d got %0d",
                             $time, want.is_last, ev_last);
                end
            end
        end
        ready_tick++;
        if (ready_tick % 64 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 2) != 0);
            default: out_ready <= (ready_tick[1:0] == 2'b00);
        endcase
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        int pick;
        int reps;
        int pv;
        logic [CFG_DATA_W-1:0] xs, ys, org, db, thr;
        touch_word_t w;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words at reset settings
        pending_words.push_back(zone_word(0, 0, 0, 1023, 1023));
        pending_words.push_back(zone_word(15, -1024, -1024, 1023, 1023));
        pending_words.push_back(zone_word(3, 1023, 1023, 0, 0));
        pending_words.push_back(zone_word(5, 300, 100, 50, 50));
        pending_words.push_back(sample_word(KIND_X, 1000));
        pending_words.push_back(sample_word(KIND_Y, 500));
        pending_words.push_back(sample_word(KIND_PRESS, 4095));
        pending_words.push_back(sample_word(KIND_PRESS, 51));
        pending_words.push_back(sample_word(KIND_PRESS, 50));      // at threshold
        pending_words.push_back(sample_word(KIND_PRESS, 0));
        pending_words.push_back(sample_word(KIND_X, 1010));        // inside deadband
        pending_words.push_back(sample_word(KIND_X, 4095));        // saturates
        pending_words.push_back(sample_word(KIND_OTHER, 4095));
        pending_words.push_back(sample_word(KIND_Y, 4095));
        pending_words.push_back(sample_word(KIND_X, 1000));
        pending_words.push_back(sample_word(KIND_Y, 500));
        pending_words.push_back(ctrl_word(FUNC_SET_EN, 5, 1'b0));
        pending_words.push_back(sample_word(KIND_PRESS, 4095));
        pending_words.push_back(ctrl_word(FUNC_SET_EN, 5, 1'b1));
        pending_words.push_back(ctrl_word(FUNC_PAUSE, 0, 1'b0));
        pending_words.push_back(sample_word(KIND_PRESS, 4095));    // nested, no hit
        pending_words.push_back(ctrl_word(FUNC_RESUME, 0, 1'b0));
        pending_words.push_back(sample_word(KIND_PRESS, 4095));
        pending_words.push_back(ctrl_word(FUNC_RSVD_6, 0, 1'b1));
        pending_words.push_back(ctrl_word(FUNC_RSVD_7, 0, 1'b1));
        pending_words.push_back(ctrl_word(FUNC_CLEAR, 0, 1'b0));

        for (int ph = 1; ph < PHASES; ph++) begin
            drain();
            case (ph)
                1: begin xs = 16'hFFFF; ys = 16'hFFFF; org = 0; db = 0; thr = 0; end
                2: begin xs = 0; ys = 0; org = 1023; db = 4095; thr = 4095; end
                3: begin
                    xs = RST_X_SCALE; ys = RST_Y_SCALE; org = RST_Y_ORIGIN;
                    db = RST_DEADBAND; thr = RST_THRESHOLD;
                end
                4: begin
                    xs = $urandom_range(8000, 40000); ys = $urandom_range(8000, 40000);
                    org = $urandom_range(0, 1023); db = $urandom_range(0, 40);
                    thr = $urandom_range(0, 300);
                end
                default: begin
                    xs = $urandom_range(0, 65535); ys = $urandom_range(0, 65535);
                    org = $urandom_range(0, 1023); db = $urandom_range(0, 4095);
                    thr = $urandom_range(0, 4095);
                end
            endcase
            write_reg(CFG_X_SCALE, xs);
            write_reg(CFG_Y_SCALE, ys);
            write_reg(CFG_Y_ORIGIN, org);
            write_reg(CFG_DEADBAND, db);
            write_reg(CFG_THRESHOLD, thr);
            @(negedge clk);

            n = 0;
            while (n < RANDOM_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    // large overlapping zones everywhere: up to sixteen hits
                    for (int z = 0; z < ZONE_COUNT; z++)
                        pending_words.push_back(zone_word(z,
                            int'($urandom_range(0, 39)) - 40,
                            int'($urandom_range(0, 524)) - 1024,
                            $urandom_range(900, 1023), $urandom_range(900, 1023)));
                    n += ZONE_COUNT;
                end else if (pick < 60) begin
                    // touch: position, one or more presses, usually a lift
                    pending_words.push_back(sample_word(KIND_X, $urandom_range(0, 4095)));
                    pending_words.push_back(sample_word(KIND_Y, $urandom_range(0, 4095)));
                    reps = $urandom_range(1, 3);
                    repeat (reps) begin
                        pv = (cfg_threshold == 12'hFFF) ? $urandom_range(1, 4095)
                                                        : $urandom_range(cfg_threshold + 1, 4095);
                        pending_words.push_back(sample_word(KIND_PRESS, pv));
                    end
                    n += 2 + reps;
                    if ($urandom_range(0, 4) != 0) begin
                        pending_words.push_back(sample_word(KIND_PRESS, 0));
                        n++;
                    end
                end else if (pick < 75) begin
                    if ($urandom_range(0, 4) == 0) begin
                        w = rand_word();
                        w.func = FUNC_WRITE;
                        pending_words.push_back(w);
                    end else begin
                        pending_words.push_back(zone_word($urandom_range(0, ZONE_COUNT - 1),
                            int'($urandom_range(0, 700)) - 100,
                            int'($urandom_range(0, 700)) - 400,
                            $urandom_range(0, 600), $urandom_range(0, 600)));
                    end
                    n++;
                end else if (pick < 83) begin
                    pending_words.push_back(ctrl_word(FUNC_SET_EN,
                        $urandom_range(0, ZONE_COUNT - 1), $urandom_range(0, 1)));
                    n++;
                end else if (pick < 88) begin
                    pending_words.push_back(ctrl_word(FUNC_PAUSE, 0, 1'b0));
                    n++;
                end else if (pick < 93) begin
                    pending_words.push_back(ctrl_word(FUNC_RESUME, 0, 1'b0));
                    n++;
                end else if (pick < 95) begin
                    pending_words.push_back(ctrl_word(FUNC_CLEAR, 0, 1'b0));
                    n++;
                end else begin
                    w = rand_word();
                    pending_words.push_back(w);
                    if (w.func <= FUNC_CLEAR &&
                        !(w.func == FUNC_SAMPLE && w.kind == KIND_OTHER))
                        n++;
                end
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
